// File: hdl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	// Fixed field widths of the item and result words
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 4;
	localparam int CADDR_W   = 11;
	localparam int CFG_IDX_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEF_FG = 8'd0,
		REG_DEF_BG = 8'd1
	} reg_idx_t;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd0;
	localparam logic [COLOR_W-1:0] RESET_FG     = 4'd7;
	localparam logic [COLOR_W-1:0] RESET_BG     = 4'd0;

	typedef struct packed {
		logic [CHAR_W-1:0]  code;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} cell_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SCROLL,
		ST_BLANK,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// File: hdl/tcw_if.sv
`default_nettype none
interface tcw_cmd_if;
	import tcw_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [CHAR_W-1:0]  char_code;
	logic [COLOR_W-1:0] fg_color;
	logic [COLOR_W-1:0] bg_color;
	logic [CADDR_W-1:0] cell_address;

	modport source (output valid, command, char_code, fg_color, bg_color, cell_address,
		input ready);
	modport sink (input valid, command, char_code, fg_color, bg_color, cell_address,
		output ready);
endinterface

interface tcw_res_if;
	import tcw_pkg::*;
	logic               valid;
	logic               ready;
	logic [CADDR_W-1:0] cursor_at;
	logic [CHAR_W-1:0]  cell_char;
	logic [COLOR_W-1:0] cell_fg;
	logic [COLOR_W-1:0] cell_bg;
	logic               scrolled;

	modport source (output valid, cursor_at, cell_char, cell_fg, cell_bg, scrolled,
		input ready);
	modport sink (input valid, cursor_at, cell_char, cell_fg, cell_bg, scrolled,
		output ready);
endinterface

interface tcw_cfg_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COLOR_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/text_console_writer_core.sv
// Text console writer over a COLUMNS x ROWS cell memory (one write, one read port).
// From the accepting edge to result valid, a word passes execute and finish; a
// read in range adds a read wait, a clear a blanking pass over every cell, and a
// scroll a copy pass and a blank of the bottom row. Words are taken one at a time
// (idle, execute, finish). Reset: control clears at once, then a clearing pass
// writes every cell blank, during which no command word is taken.
`default_nettype none
module text_console_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire        clk,
	input  wire        arst_n,
	tcw_cmd_if.sink    cmd,
	tcw_res_if.source  res,
	tcw_cfg_if.sink    cfg
);
	import tcw_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COPY_N = CELLS - COLUMNS;
	localparam int AW     = $clog2(CELLS);
	localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PW     = (AW > CADDR_W) ? AW : CADDR_W;

	// Cell memory: code, foreground, background per entry
	cell_t mem [CELLS];

	state_t             state_q, state_d;
	logic [COLOR_W-1:0] def_fg_q, def_bg_q;
	logic [AW-1:0]      cursor_q;
	logic [CW-1:0]      col_q;
	logic [AW-1:0]      sweep_q;
	logic [AW-1:0]      copy_idx_q;
	logic               cp_valid_s1;
	logic [AW-1:0]      cp_addr_s1;
	logic               init_q;
	logic               out_valid_q;

	// Captured command word
	cmd_t               cmd_q;
	logic [CHAR_W-1:0]  code_q;
	logic [COLOR_W-1:0] fg_q, bg_q;
	logic [CADDR_W-1:0] caddr_q;

	// Result under construction and the output register
	cell_t              res_cell_q;
	logic               res_scrolled_q;
	logic [CADDR_W-1:0] out_cursor_q;
	cell_t              out_cell_q;
	logic               out_scrolled_q;

	// Memory port controls
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	cell_t              mem_wdata;
	logic [AW-1:0]      mem_raddr;
	cell_t              rd_data_q;

	logic               at_end;
	logic               last_row;
	logic               in_range;
	logic               out_free;
	logic               copy_done;
	logic [AW-1:0]      nl_cursor;
	logic [PW-1:0]      caddr_wide;
	logic [PW-1:0]      cursor_wide;

	assign at_end      = (cursor_q == AW'(CELLS - 1));
	assign last_row    = (cursor_q >= AW'(COPY_N));
	assign caddr_wide  = PW'(caddr_q);
	assign in_range    = (caddr_wide < PW'(CELLS));
	assign out_free    = !out_valid_q || res.ready;
	assign copy_done   = (copy_idx_q == AW'(COPY_N));
	// Step to the start of the next row
	assign nl_cursor   = cursor_q - AW'(col_q) + AW'(COLUMNS);
	assign cursor_wide = PW'(cursor_q);

	assign cmd.ready    = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign res.valid    = out_valid_q;
	assign res.cursor_at = out_cursor_q;
	assign res.cell_char = out_cell_q.code;
	assign res.cell_fg   = out_cell_q.fg;
	assign res.cell_bg   = out_cell_q.bg;
	assign res.scrolled  = out_scrolled_q;

	// Next state and memory port strobes
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cursor_q;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_PUT: begin
						if (code_q == NEWLINE_CODE) begin
							state_d = last_row ? ST_SCROLL : ST_FIN;
						end else if (code_q != BLANK_CODE) begin
							// Write at the cursor; a scroll then moves it up with its row
							mem_we    = 1'b1;
							mem_waddr = cursor_q;
							mem_wdata = '{code: code_q, fg: fg_q, bg: bg_q};
							state_d   = at_end ? ST_SCROLL : ST_FIN;
						end else begin
							state_d = ST_FIN;
						end
					end
					CMD_CLEAR: state_d = ST_BLANK;
					CMD_READ: begin
						if (in_range) begin
							mem_raddr = caddr_wide[AW-1:0];
							state_d   = ST_RDWAIT;
						end else begin
							state_d = ST_FIN;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_RDWAIT: state_d = ST_FIN;
			ST_SCROLL: begin
				// Read one row ahead, write the word back in the next cycle
				if (!copy_done) mem_raddr = copy_idx_q + AW'(COLUMNS);
				else state_d = ST_BLANK;
				if (cp_valid_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cp_addr_s1;
					mem_wdata = rd_data_q;
				end
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = init_q ? cell_t'{code: BLANK_CODE, fg: RESET_FG, bg: RESET_BG}
				                   : cell_t'{code: BLANK_CODE, fg: def_fg_q, bg: def_bg_q};
				if (sweep_q == AW'(CELLS - 1)) state_d = init_q ? ST_IDLE : ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[mem_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BLANK;
			def_fg_q    <= RESET_FG;
			def_bg_q    <= RESET_BG;
			cursor_q    <= '0;
			col_q       <= '0;
			sweep_q     <= '0;
			copy_idx_q  <= '0;
			cp_valid_s1 <= 1'b0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Register writes are taken at any time
			if (cfg.valid) begin
				case (cfg.index)
					REG_DEF_FG: def_fg_q <= cfg.data;
					REG_DEF_BG: def_bg_q <= cfg.data;
					default: ;
				endcase
			end

			cp_valid_s1 <= 1'b0;

			case (state_q)
				ST_EXEC: begin
					copy_idx_q <= '0;
					if (cmd_q == CMD_PUT && code_q == NEWLINE_CODE && !last_row) begin
						cursor_q <= nl_cursor;
						col_q    <= '0;
					end else if (cmd_q == CMD_PUT && code_q != NEWLINE_CODE &&
							code_q != BLANK_CODE && !at_end) begin
						cursor_q <= cursor_q + 1'b1;
						col_q    <= (col_q == CW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
					end else if (cmd_q == CMD_CLEAR) begin
						cursor_q <= '0;
						col_q    <= '0;
						sweep_q  <= '0;
					end
				end
				ST_SCROLL: begin
					if (!copy_done) begin
						cp_valid_s1 <= 1'b1;
						copy_idx_q  <= copy_idx_q + 1'b1;
					end else begin
						// Blank the bottom row and park the cursor at its start
						sweep_q  <= AW'(COPY_N);
						cursor_q <= AW'(COPY_N);
						col_q    <= '0;
					end
				end
				ST_BLANK: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(CELLS - 1)) init_q <= 1'b0;
				end
				default: ;
			endcase

			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			cmd_q   <= cmd_t'(cmd.command);
			code_q  <= cmd.char_code;
			fg_q    <= cmd.fg_color;
			bg_q    <= cmd.bg_color;
			caddr_q <= cmd.cell_address;
		end
		if (state_q == ST_EXEC) begin
			res_cell_q     <= '0;
			res_scrolled_q <= 1'b0;
		end
		if (state_q == ST_SCROLL) begin
			cp_addr_s1 <= copy_idx_q;
			if (copy_done) res_scrolled_q <= 1'b1;
		end
		if (state_q == ST_RDWAIT) res_cell_q <= rd_data_q;
		if (state_q == ST_FIN && out_free) begin
			out_cursor_q   <= cursor_wide[CADDR_W-1:0];
			out_cell_q     <= res_cell_q;
			out_scrolled_q <= res_scrolled_q;
		end
	end

endmodule
`default_nettype wire

// File: hdl/tcw_checker.sv
`default_nettype none
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire        clk,
	input wire        arst_n,
	input wire        cmd_valid,
	input wire        cmd_ready,
	input wire        res_valid,
	input wire        res_ready,
	input wire [10:0] cursor_at,
	input wire [7:0]  cell_char,
	input wire [3:0]  cell_fg,
	input wire [3:0]  cell_bg,
	input wire        scrolled
);
	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [10:0] LAST_ROW_AT = 11'(CELLS - COLUMNS);

	// Hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
		$stable(cursor_at) && $stable(cell_char) && $stable(cell_fg) &&
		$stable(cell_bg) && $stable(scrolled))
		else $error("result word changed while stalled");

	// One word at a time: drop ready right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another is in flight");

	// A scroll leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && scrolled |-> cursor_at == LAST_ROW_AT)
		else $error("scroll left cursor off the bottom row start");

	// Cursor stays inside the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && CELLS <= 2048 |-> int'(cursor_at) < CELLS)
		else $error("cursor beyond the last cell");

endmodule

bind text_console_writer_core tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.cursor_at (res.cursor_at),
	.cell_char (res.cell_char),
	.cell_fg   (res.cell_fg),
	.cell_bg   (res.cell_bg),
	.scrolled  (res.scrolled)
);
`default_nettype wire
